// File: design/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: design/ile_pkg.sv
package ile_pkg;

  // Fixed field widths of the stream payloads.
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 112;

  // Operation codes carried in the request.
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_INSERT     = 3'd4,
    FN_REMOVE     = 3'd5,
    FN_READ_AT    = 3'd6,
    FN_CLEAR      = 3'd7
  } func_code_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_ERR  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2
  } cell_op_t;

  // Control sequence of one request.
  typedef enum logic {
    S_IDLE   = 1'b0,
    S_FINISH = 1'b1
  } state_t;

endpackage

// File: design/indexed_list_engine.sv
// Indexed list engine: an ordered list of up to CAPACITY signed 32-bit
// values held in a chain of cells, front in cell 0. In the accept cycle the
// popped, removed or read value is picked from the cells and the cells shift
// in parallel; in the finish state the new back value is picked through the
// same cell select and the result is registered once the output is free.
// No request is taken in the finish state, but one is taken while a finished
// result still waits on the output. Status 2 (full) is checked before any
// index check; errors return value 0 and leave the list as is.
`include "assert_macros.svh"
module indexed_list_engine import ile_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // func[2:0], position[10:3], write_value[42:11], zero fill above
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // read_value[31:0], status[33:32], entry_count[40:34], is_empty[41],
  // front_value[73:42], back_value[105:74], zero fill above
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int PW = (IW > POS_W) ? IW : POS_W;
  localparam int EW = (IW > COUNT_W) ? IW : COUNT_W;
  localparam logic [IW-1:0] CAP_FILL = IW'(CAPACITY);

  // Request fields.
  func_code_t                func;
  logic [POS_W-1:0]          position;
  logic signed [DATA_W-1:0]  write_value;

  assign func        = func_code_t'(s_tdata[2:0]);
  assign position    = s_tdata[10:3];
  assign write_value = s_tdata[42:11];

  // Control and list state.
  state_t                    state, state_next;
  logic [IW-1:0]             fill, fill_next;
  status_t                   st_q, st_next;
  logic signed [DATA_W-1:0]  rv_q, rv_next;
  logic                      accept, load_out;

  // Output registers.
  logic signed [DATA_W-1:0]  read_value, front_value, back_value;
  status_t                   status;
  logic [COUNT_W-1:0]        entry_count;
  logic                      is_empty;

  // Cell chain.
  logic signed [DATA_W-1:0]  cell_value [CAPACITY];
  logic signed [DATA_W-1:0]  cell_tap   [CAPACITY];
  logic signed [DATA_W-1:0]  tap_all;
  cell_op_t                  op_req, op_bus;
  logic [PW-1:0]             at_req, rd_pos, sel_pos;
  logic                      take_rd;

  logic                      full;
  logic [PW-1:0]             pos_ext, fill_ext, last_ext;
  logic [EW-1:0]             count_ext;

  assign accept   = s_tvalid && s_tready;
  assign full     = (fill == CAP_FILL);
  assign pos_ext  = PW'(position);
  assign fill_ext = PW'(fill);
  assign last_ext = fill_ext - PW'(1);

  // Request decode: cell command, selected slot, status and new count.
  always_comb begin
    op_req    = CELL_HOLD;
    at_req    = '0;
    rd_pos    = pos_ext;
    take_rd   = 1'b0;
    st_next   = ST_OK;
    fill_next = fill;
    unique case (func)
      FN_PUSH_BACK, FN_PUSH_FRONT: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          op_req    = CELL_OPEN;
          at_req    = (func == FN_PUSH_BACK) ? fill_ext : '0;
          fill_next = fill + IW'(1);
        end
      end
      FN_INSERT: begin
        if (full) begin
          st_next = ST_FULL;
        end else if (pos_ext > fill_ext) begin
          st_next = ST_ERR;
        end else begin
          op_req    = CELL_OPEN;
          at_req    = pos_ext;
          fill_next = fill + IW'(1);
        end
      end
      FN_POP_FRONT: begin
        rd_pos = '0;
        if (fill == '0) begin
          st_next = ST_ERR;
        end else begin
          op_req    = CELL_CLOSE;
          take_rd   = 1'b1;
          fill_next = fill - IW'(1);
        end
      end
      FN_POP_BACK: begin
        rd_pos = last_ext;
        if (fill == '0) begin
          st_next = ST_ERR;
        end else begin
          take_rd   = 1'b1;
          fill_next = fill - IW'(1);
        end
      end
      FN_REMOVE: begin
        if (pos_ext >= fill_ext) begin
          st_next = ST_ERR;
        end else begin
          op_req    = CELL_CLOSE;
          at_req    = pos_ext;
          take_rd   = 1'b1;
          fill_next = fill - IW'(1);
        end
      end
      FN_READ_AT: begin
        if (pos_ext >= fill_ext) begin
          st_next = ST_ERR;
        end else begin
          take_rd = 1'b1;
        end
      end
      FN_CLEAR: begin
        fill_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign rv_next = take_rd ? tap_all : '0;
  assign op_bus  = accept ? op_req : CELL_HOLD;
  assign sel_pos = (state == S_IDLE) ? rd_pos : last_ext;

  // Chain of cells with neighbor links.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in, right_in;
    if (i == 0) begin : g_first
      assign left_in = write_value;
    end else begin : g_mid_l
      assign left_in = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = cell_value[i];
    end else begin : g_mid_r
      assign right_in = cell_value[i+1];
    end
    ile_cell #(
      .IDX (i),
      .PW  (PW)
    ) u_cell (
      .clk         (clk),
      .op          (op_bus),
      .at          (at_req),
      .sel         (sel_pos),
      .write_value (write_value),
      .left        (left_in),
      .right       (right_in),
      .value       (cell_value[i]),
      .tap         (cell_tap[i])
    );
  end

  // Combine the one-hot taps of all cells.
  always_comb begin
    tap_all = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      tap_all = tap_all | cell_tap[k];
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State outputs. No transfer is taken while reset is held.
  always_comb begin
    s_tready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = !rst;
      end
      S_FINISH: begin
        load_out = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fill <= fill_next;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign count_ext = EW'(fill);

  // Per-request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      st_q <= st_next;
      rv_q <= rv_next;
    end
    if (load_out) begin
      read_value  <= rv_q;
      status      <= st_q;
      entry_count <= count_ext[COUNT_W-1:0];
      is_empty    <= (fill == '0);
      front_value <= (fill == '0) ? '0 : cell_value[0];
      back_value  <= (fill == '0) ? '0 : tap_all;
    end
  end

  assign m_tdata = {6'd0, back_value, front_value, is_empty, entry_count, status, read_value};

  `ASSERT_IMPLIES(a_fill_bound, clk, rst, 1'b1, fill <= CAP_FILL)
  `ASSERT_NEXT(a_accept_finish, clk, rst, accept, state == S_FINISH)
  `ASSERT_IMPLIES(a_empty_flag, clk, rst, m_tvalid, is_empty == (entry_count == '0) || CAPACITY > 127)
  `ASSERT_IMPLIES(a_full_status, clk, rst, load_out && st_q == ST_FULL, fill == CAP_FILL)
  `ASSERT_IMPLIES(a_err_zero, clk, rst, load_out && st_q != ST_OK, rv_q == '0)

endmodule

// File: design/ile_cell.sv
// One slot of the list. On an open command the cells at and above the
// position shift up by one and the cell at the position takes the new value;
// on a close command the cells at and above the position take their upper
// neighbor. Each cell also drives its value onto the select tap when its
// index matches the select position, and zero otherwise.
module ile_cell import ile_pkg::*; #(
  parameter int IDX = 0,
  parameter int PW  = 8
) (
  input  logic                     clk,
  input  cell_op_t                 op,
  input  logic [PW-1:0]            at,
  input  logic [PW-1:0]            sel,
  input  logic signed [DATA_W-1:0] write_value,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  output logic signed [DATA_W-1:0] value,
  output logic signed [DATA_W-1:0] tap
);

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  // Slot update from the broadcast command and the neighbors.
  always_ff @(posedge clk) begin
    unique case (op)
      CELL_OPEN: begin
        if (MY_IDX > at) begin
          value <= left;
        end else if (MY_IDX == at) begin
          value <= write_value;
        end
      end
      CELL_CLOSE: begin
        if (MY_IDX >= at) begin
          value <= right;
        end
      end
      default: begin
      end
    endcase
  end

  // Contribution to the shared select tap.
  assign tap = (MY_IDX == sel) ? value : '0;

endmodule

// File: tb/sv/list_checker.sv
// Watches both stream channels of the list engine, keeps its own copy of
// the list, and compares every result transfer against the oldest
// predicted result.
module list_checker import ile_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  // func[2:0], position[10:3], write_value[42:11], zero fill above
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  // read_value[31:0], status[33:32], entry_count[40:34], is_empty[41],
  // front_value[73:42], back_value[105:74], zero fill above
  input  logic [M_DATA_W-1:0] m_tdata,
  output int                  mismatches,
  output int                  pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0]  read_value;
    status_t                   status;
    logic        [COUNT_W-1:0] entry_count;
    logic                      is_empty;
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  back_value;
  } list_result_t;

  // Shadow copy of the list: front in entry 0, size entries in use.
  logic signed [DATA_W-1:0] shadow_list [CAPACITY];
  int                       size;
  list_result_t             expected_results [$];

  // Applies one request to the shadow list and builds the result it gives.
  task automatic apply_request(input func_code_t fn, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] wv,
                               output list_result_t res);
    bit adds;
    res = '0;
    res.status = ST_OK;
    adds = fn inside {FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT};
    // A full list refuses any addition before the index is looked at.
    if (adds && size >= CAPACITY) begin
      res.status = ST_FULL;
    end else begin
      case (fn)
        FN_PUSH_BACK: begin
          shadow_list[size] = wv;
          size++;
        end
        FN_PUSH_FRONT: begin
          for (int i = size; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = wv;
          size++;
        end
        FN_POP_FRONT: begin
          if (size == 0) begin
            res.status = ST_ERR;
          end else begin
            res.read_value = shadow_list[0];
            for (int i = 0; i + 1 < size; i++) shadow_list[i] = shadow_list[i+1];
            size--;
          end
        end
        FN_POP_BACK: begin
          if (size == 0) begin
            res.status = ST_ERR;
          end else begin
            size--;
            res.read_value = shadow_list[size];
          end
        end
        FN_INSERT: begin
          if (pos > size) begin
            res.status = ST_ERR;
          end else begin
            for (int i = size; i > pos; i--) shadow_list[i] = shadow_list[i-1];
            shadow_list[pos] = wv;
            size++;
          end
        end
        FN_REMOVE: begin
          if (pos >= size) begin
            res.status = ST_ERR;
          end else begin
            res.read_value = shadow_list[pos];
            for (int i = pos; i + 1 < size; i++) shadow_list[i] = shadow_list[i+1];
            size--;
          end
        end
        FN_READ_AT: begin
          if (pos >= size) res.status = ST_ERR;
          else res.read_value = shadow_list[pos];
        end
        default: begin
          size = 0;
        end
      endcase
    end
    res.entry_count = COUNT_W'(size);
    res.is_empty    = (size == 0);
    res.front_value = (size == 0) ? '0 : shadow_list[0];
    res.back_value  = (size == 0) ? '0 : shadow_list[size-1];
  endtask

  // Counts one field mismatch and reports the first few of them.
  task automatic check_field(input string field, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch in %s: expected %h, got %h", field, want, got);
    end
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    size = 0;
  end

  // Results are checked before new requests are predicted, so a result can
  // never be matched against a request from the same edge.
  always @(posedge clk) begin
    list_result_t want;
    list_result_t fresh;
    if (rst) begin
      size = 0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result transfer with nothing expected: %h", m_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("read_value", m_tdata[31:0], want.read_value);
          check_field("status", 32'(m_tdata[33:32]), 32'(want.status));
          check_field("entry_count", 32'(m_tdata[40:34]), 32'(want.entry_count));
          check_field("is_empty", 32'(m_tdata[41]), 32'(want.is_empty));
          check_field("front_value", m_tdata[73:42], want.front_value);
          check_field("back_value", m_tdata[105:74], want.back_value);
        end
      end
      if (s_tvalid && s_tready) begin
        apply_request(func_code_t'(s_tdata[2:0]), s_tdata[10:3], s_tdata[42:11], fresh);
        expected_results.push_back(fresh);
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: tb/sv/testbench.sv
// Drives requests into the list engine and gives the verdict; all result
// checking happens in the list checker beside the block.
module testbench;
  import ile_pkg::*;

  localparam int LIST_CAPACITY  = 64;
  localparam int ITEMS          = 1900;
  localparam int SEGMENT        = 100;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  int                  mismatches;
  int                  pending;
  int                  list_size;
  logic                calm;

  indexed_list_engine #(.CAPACITY(LIST_CAPACITY)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  list_checker #(.CAPACITY(LIST_CAPACITY)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sends one request, with a random gap first unless idling is off. The
  // list size is tracked only to aim positions at valid indexes.
  task automatic send(input func_code_t fn, input logic [POS_W-1:0] pos,
                      input logic [DATA_W-1:0] wv);
    while (!calm && $urandom_range(99) < 13) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, wv, pos, fn};
    do @(posedge clk); while (!s_tready);
    case (fn)
      FN_PUSH_BACK, FN_PUSH_FRONT: if (list_size < LIST_CAPACITY) list_size++;
      FN_INSERT: if (list_size < LIST_CAPACITY && pos <= list_size) list_size++;
      FN_POP_FRONT, FN_POP_BACK: if (list_size > 0) list_size--;
      FN_REMOVE: if (pos < list_size) list_size--;
      FN_CLEAR: list_size = 0;
      default: ;
    endcase
  endtask

  // The result side stalls at random except in the calm stretch.
  initial begin
    forever begin
      @(negedge clk);
      m_tready <= calm || ($urandom_range(99) >= 13);
    end
  end

  // Ends the run when nothing has been transferred for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(negedge rst);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    func_code_t          fn;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   wv;
    int                  r;
    int                  seg;
    int                  mode;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    calm      = 1'b0;
    list_size = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: value extremes, index limits, empty list and clear.
    send(FN_PUSH_BACK, 8'd170, 32'h7fff_ffff);
    send(FN_PUSH_FRONT, 8'd85, 32'h8000_0000);
    send(FN_READ_AT, 8'd0, 32'h0);
    send(FN_READ_AT, 8'd1, 32'h0);
    send(FN_READ_AT, 8'd2, 32'h0);
    send(FN_INSERT, 8'd1, 32'hffff_ffff);
    send(FN_INSERT, 8'd3, 32'h0);
    send(FN_INSERT, 8'd255, 32'h5555_aaaa);
    send(FN_REMOVE, 8'd5, 32'h0);
    send(FN_REMOVE, 8'd1, 32'h0);
    send(FN_READ_AT, 8'd255, 32'h0);
    send(FN_POP_FRONT, 8'd0, 32'h0);
    send(FN_POP_BACK, 8'd0, 32'h0);
    send(FN_POP_BACK, 8'd0, 32'h0);
    // Everything below starts on an empty list.
    send(FN_POP_BACK, 8'd0, 32'h0);
    send(FN_POP_FRONT, 8'd0, 32'h0);
    send(FN_REMOVE, 8'd0, 32'h0);
    send(FN_READ_AT, 8'd0, 32'h0);
    send(FN_CLEAR, 8'd0, 32'h0);
    send(FN_PUSH_BACK, 8'd0, 32'd5);
    send(FN_PUSH_BACK, 8'd0, 32'd6);
    send(FN_CLEAR, 8'd0, 32'h0);
    send(FN_INSERT, 8'd0, 32'h1234_5678);
    send(FN_READ_AT, 8'd0, 32'h0);

    // Random part in segments that grow the list, mix, or shrink it.
    for (int n = 0; n < ITEMS; n++) begin
      seg  = n / SEGMENT;
      mode = seg % 4;
      if (n % SEGMENT == 0) begin
        calm = (seg == 8 || seg == 9);
        if (seg == 5 || seg == 12) begin
          @(negedge clk);
          s_tvalid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
      r = $urandom_range(99);
      if (mode == 0) begin
        if (r < 28) fn = FN_PUSH_BACK;
        else if (r < 52) fn = FN_PUSH_FRONT;
        else if (r < 76) fn = FN_INSERT;
        else if (r < 84) fn = FN_READ_AT;
        else if (r < 89) fn = FN_REMOVE;
        else if (r < 93) fn = FN_POP_FRONT;
        else if (r < 99) fn = FN_POP_BACK;
        else fn = FN_CLEAR;
      end else if (mode == 2) begin
        if (r < 25) fn = FN_POP_FRONT;
        else if (r < 50) fn = FN_POP_BACK;
        else if (r < 75) fn = FN_REMOVE;
        else if (r < 85) fn = FN_READ_AT;
        else if (r < 90) fn = FN_PUSH_BACK;
        else if (r < 94) fn = FN_PUSH_FRONT;
        else if (r < 99) fn = FN_INSERT;
        else fn = FN_CLEAR;
      end else begin
        if (r < 3) fn = FN_CLEAR;
        else fn = func_code_t'($urandom_range(6));
      end
      // Mostly valid indexes, some anywhere in the field's range.
      r = $urandom_range(99);
      if (r < 15) pos = POS_W'($urandom_range(255));
      else if (fn == FN_INSERT) pos = POS_W'($urandom_range(list_size));
      else if (list_size > 0) pos = POS_W'($urandom_range(list_size - 1));
      else pos = '0;
      r = $urandom_range(99);
      if (r < 8) begin
        case ($urandom_range(3))
          0: wv = 32'h7fff_ffff;
          1: wv = 32'h8000_0000;
          2: wv = 32'h0;
          default: wv = 32'hffff_ffff;
        endcase
      end else begin
        wv = $urandom;
      end
      send(fn, pos, wv);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    calm = 1'b0;

    // Drain, then give the block a few more cycles to show stray results.
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/ile_pkg.sv
design/ile_cell.sv
design/indexed_list_engine.sv
tb/sv/list_checker.sv
tb/sv/testbench.sv
